@@ rtl/owm_pkg.sv @@
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the one-wire bus master: command codes,
// configuration register map, reset values and fixed slot timings.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = $clog2(CFG_COUNT);
    localparam int TICK_W    = 10;

    // Longest chain of zero-length phases that one request can pass through.
    localparam int SETTLE_STEPS = 4;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREAMBLE      = 3'd0,
        CFG_RESET_LOW     = 3'd1,
        CFG_PRESENCE_WAIT = 3'd2,
        CFG_RESET_TAIL    = 3'd3,
        CFG_WRITE_ONE_LOW = 3'd4,
        CFG_WRITE_ZERO_LOW= 3'd5,
        CFG_READ_LOW      = 3'd6,
        CFG_READ_SAMPLE   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] preamble_ticks;
        logic [TICK_W-1:0] reset_low_ticks;
        logic [TICK_W-1:0] presence_wait_ticks;
        logic [TICK_W-1:0] reset_tail_ticks;
        logic [TICK_W-1:0] write_one_low_ticks;
        logic [TICK_W-1:0] write_zero_low_ticks;
        logic [TICK_W-1:0] read_low_ticks;
        logic [TICK_W-1:0] read_sample_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET_VALUE = '{
        preamble_ticks:       10'd10,
        reset_low_ticks:      10'd520,
        presence_wait_ticks:  10'd57,
        reset_tail_ticks:     10'd200,
        write_one_low_ticks:  10'd6,
        write_zero_low_ticks: 10'd60,
        read_low_ticks:       10'd2,
        read_sample_ticks:    10'd8
    };

    localparam logic [TICK_W-1:0] WRITE_ONE_RECOVER  = 10'd55;
    localparam logic [TICK_W-1:0] WRITE_ZERO_RECOVER = 10'd5;
    localparam logic [TICK_W-1:0] READ_SLOT_TAIL     = 10'd55;

endpackage

@@ rtl/owm_cmd_if.sv @@
// ----------------------------------------------------------------------------
// owm_cmd_if
// Request channel of the one-wire bus master: tick or command plus bus level.
// ----------------------------------------------------------------------------
interface owm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] write_data;
    logic       line_level;

    modport source (output valid, output op, output write_data, output line_level,
                    input ready);
    modport sink   (input valid, input op, input write_data, input line_level,
                    output ready);
endinterface

@@ rtl/owm_res_if.sv @@
// ----------------------------------------------------------------------------
// owm_res_if
// Result channel of the one-wire bus master: one result per request.
// ----------------------------------------------------------------------------
interface owm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_data, output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_data, input rejected, output ready);
endinterface

@@ rtl/owm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Timing register file of the one-wire bus master, written through a plain
// write port and presented as one structure.
// ----------------------------------------------------------------------------
module owm_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owm_pkg::TICK_W-1:0]    cfg_wdata,
    output owm_pkg::cfg_t                 cfg
);
    import owm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PREAMBLE:       cfg_next.preamble_ticks       = cfg_wdata;
                CFG_RESET_LOW:      cfg_next.reset_low_ticks      = cfg_wdata;
                CFG_PRESENCE_WAIT:  cfg_next.presence_wait_ticks  = cfg_wdata;
                CFG_RESET_TAIL:     cfg_next.reset_tail_ticks     = cfg_wdata;
                CFG_WRITE_ONE_LOW:  cfg_next.write_one_low_ticks  = cfg_wdata;
                CFG_WRITE_ZERO_LOW: cfg_next.write_zero_low_ticks = cfg_wdata;
                CFG_READ_LOW:       cfg_next.read_low_ticks       = cfg_wdata;
                CFG_READ_SAMPLE:    cfg_next.read_sample_ticks    = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET_VALUE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/one_wire_bus_master.sv @@
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master sequencer driven by microsecond ticks and commands.
// ----------------------------------------------------------------------------
// Each request (a tick or a reset, write-byte or read-byte command) yields
// exactly one result, presented the cycle after it is taken. A new request is
// taken in every cycle in which the result register is empty or its result is
// being taken, so the sustained rate is one request per clock; the limit is the
// single result register and the phase update that resolves any run of
// zero-length phases within the same cycle. Timing registers should be written
// while no operation is in progress.
module one_wire_bus_master (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owm_pkg::TICK_W-1:0]    cfg_wdata,
    owm_cmd_if.sink                       cmd,
    owm_res_if.source                     res
);
    import owm_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PRE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_LOW,
        PH_WR_REC,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_TAIL
    } phase_t;

    typedef struct packed {
        phase_t     ph;
        logic [2:0] bit_idx;
        logic [7:0] shift;
        logic       pres;
    } walk_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } res_t;

    cfg_t cfg;

    owm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    phase_t            phase_reg,   phase_next;
    logic [TICK_W-1:0] count_reg,   count_next;
    logic [2:0]        bit_reg,     bit_next;
    logic [7:0]        shift_reg,   shift_next;
    op_t               cur_op_reg,  cur_op_next;
    logic              pres_reg,    pres_next;
    logic              valid_reg,   valid_next;
    res_t              res_reg,     res_next;

    logic accept;

    function automatic logic [TICK_W-1:0] phase_len(phase_t p, logic obit, cfg_t c);
        case (p)
            PH_PRE:      return c.preamble_ticks;
            PH_RST_LOW:  return c.reset_low_ticks;
            PH_RST_WAIT: return c.presence_wait_ticks;
            PH_RST_TAIL: return c.reset_tail_ticks;
            PH_WR_LOW:   return obit ? c.write_one_low_ticks : c.write_zero_low_ticks;
            PH_WR_REC:   return obit ? WRITE_ONE_RECOVER : WRITE_ZERO_RECOVER;
            PH_RD_LOW:   return c.read_low_ticks;
            PH_RD_WAIT:  return c.read_sample_ticks;
            PH_RD_TAIL:  return READ_SLOT_TAIL;
            default:     return '0;
        endcase
    endfunction

    function automatic logic is_low(phase_t p);
        return (p == PH_RST_LOW) || (p == PH_WR_LOW) || (p == PH_RD_LOW);
    endfunction

    // Action taken when a phase runs out: next phase plus sampled data.
    function automatic walk_t finish(walk_t w, op_t cop, logic line);
        walk_t r;
        r = w;
        case (w.ph)
            PH_PRE:
            begin
                case (cop)
                    OP_RESET: r.ph = PH_RST_LOW;
                    OP_WRITE: r.ph = PH_WR_LOW;
                    OP_READ:  r.ph = PH_RD_LOW;
                    default:  r.ph = PH_IDLE;
                endcase
            end
            PH_RST_LOW:  r.ph = PH_RST_WAIT;
            PH_RST_WAIT:
            begin
                r.pres = ~line;
                r.ph   = PH_RST_TAIL;
            end
            PH_WR_LOW:   r.ph = PH_WR_REC;
            PH_WR_REC:
            begin
                if (w.bit_idx == 3'd7)
                begin
                    r.ph = PH_IDLE;
                end
                else
                begin
                    r.bit_idx = w.bit_idx + 3'd1;
                    r.ph      = PH_WR_LOW;
                end
            end
            PH_RD_LOW:   r.ph = PH_RD_WAIT;
            PH_RD_WAIT:
            begin
                r.shift = {line, w.shift[7:1]};
                r.ph    = PH_RD_TAIL;
            end
            PH_RD_TAIL:
            begin
                if (w.bit_idx == 3'd7)
                begin
                    r.ph = PH_IDLE;
                end
                else
                begin
                    r.bit_idx = w.bit_idx + 3'd1;
                    r.ph      = PH_RD_LOW;
                end
            end
            default:     r.ph = PH_IDLE;
        endcase
        return r;
    endfunction

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = !valid_reg || res.ready;

    always_comb
    begin
        walk_t w;
        logic  settle;
        op_t   op_in;

        op_in       = op_t'(cmd.op);
        w.ph        = phase_reg;
        w.bit_idx   = bit_reg;
        w.shift     = shift_reg;
        w.pres      = pres_reg;
        count_next  = count_reg;
        cur_op_next = cur_op_reg;
        settle      = 1'b0;
        res_next    = '0;

        if (op_in != OP_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                res_next.rejected  = 1'b1;
                res_next.drive_low = is_low(phase_reg);
            end
            else
            begin
                cur_op_next = op_in;
                w.bit_idx   = 3'd0;
                w.shift     = (op_in == OP_WRITE) ? cmd.write_data : 8'd0;
                w.pres      = 1'b0;
                w.ph        = PH_PRE;
                count_next  = '0;
                settle      = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            res_next.drive_low = is_low(phase_reg);
            count_next = count_reg + 10'd1;
            if (count_next >= phase_len(phase_reg, shift_reg[bit_reg], cfg))
            begin
                w          = finish(w, cur_op_next, cmd.line_level);
                count_next = '0;
                settle     = 1'b1;
            end
        end

        // A phase of zero length ends on entry, sampling this request's line level.
        if (settle)
        begin
            for (int i = 0; i < SETTLE_STEPS; i++)
            begin
                if ((w.ph != PH_IDLE) && (phase_len(w.ph, w.shift[w.bit_idx], cfg) == '0))
                begin
                    w = finish(w, cur_op_next, cmd.line_level);
                end
            end
        end

        phase_next = w.ph;
        bit_next   = w.bit_idx;
        shift_next = w.shift;
        pres_next  = w.pres;

        res_next.busy_res  = (w.ph != PH_IDLE);
        res_next.done_res  = settle && (w.ph == PH_IDLE);
        res_next.presence  = res_next.done_res && (cur_op_next == OP_RESET) && w.pres;
        res_next.read_data = (res_next.done_res && (cur_op_next == OP_READ)) ? w.shift
                                                                              : 8'd0;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            count_reg  <= '0;
            bit_reg    <= 3'd0;
            shift_reg  <= 8'd0;
            cur_op_reg <= OP_TICK;
            pres_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                bit_reg    <= bit_next;
                shift_reg  <= shift_next;
                cur_op_reg <= cur_op_next;
                pres_reg   <= pres_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid     = valid_reg;
    assign res.drive_low = res_reg.drive_low;
    assign res.busy_res  = res_reg.busy_res;
    assign res.done_res  = res_reg.done_res;
    assign res.presence  = res_reg.presence;
    assign res.read_data = res_reg.read_data;
    assign res.rejected  = res_reg.rejected;

    // A completed operation leaves the sequencer idle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done result reports busy");

    // A rejected command never completes an operation.
    a_reject_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.rejected) |-> (!res_reg.done_res && res_reg.busy_res))
        else $error("rejected command completed or found bus idle");

    // The tick counter is cleared whenever the sequencer is idle.
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (count_reg == '0))
        else $error("tick counter nonzero while idle");

    // A tick taken while idle yields an all-zero result.
    a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == OP_TICK) && (phase_reg == PH_IDLE))
        |=> (valid_reg && (res_reg == '0)))
        else $error("idle tick produced a nonzero result");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the one-wire bus master. A cycle-level predictor
// follows every tick and command request and builds the result that each
// request must produce. A checker compares each returned result against the
// oldest prediction. Directed tests cover reset with presence, byte writes,
// byte reads, refused commands, zero-length and longest timings, and a
// timing change mid-phase. Random traffic then runs under four pacing modes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import owm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int LINE_LOW     = 0;
    localparam int LINE_HIGH    = 1;
    localparam int LINE_RANDOM  = 2;

    typedef enum logic [3:0] {
        BUS_IDLE,
        BUS_PREAMBLE,
        RST_LOW,
        RST_WAIT,
        RST_TAIL,
        WR_LOW,
        WR_RECOVER,
        RD_LOW,
        RD_WAIT,
        RD_TAIL
    } bus_phase_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } bus_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [9:0]  cfg_wdata;

    owm_cmd_if cmd_ch ();
    owm_res_if res_ch ();

    one_wire_bus_master i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    // Predictor state.
    logic [9:0]  timing [CFG_COUNT];
    bus_phase_t  bus_phase;
    logic [9:0]  slot_ticks;
    logic [2:0]  bit_sel;
    logic [7:0]  data_shift;
    op_t         active_op;
    logic        presence_flag;

    bus_result_t predicted_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    bit pacing_on;
    int pacing_base;
    int requests_sent;
    int ignored_requests;
    int results_checked;
    int mismatch_count;
    int ops_completed;
    int refusals_seen;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, predicted_results.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        bus_result_t got;
        bus_result_t want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got = '{drive_low: res_ch.drive_low, busy: res_ch.busy_res,
                    done: res_ch.done_res, presence: res_ch.presence,
                    read_data: res_ch.read_data, rejected: res_ch.rejected};
            results_checked++;
            if (got.done === 1'b1)
                ops_completed++;
            if (got.rejected === 1'b1)
                refusals_seen++;
            if (predicted_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with no request pending: drive=%b busy=%b done=%b",
                         $time, got.drive_low, got.busy, got.done);
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    $display("%0t: mismatch, expected drive=%b busy=%b done=%b presence=%b",
                             $time, want.drive_low, want.busy, want.done, want.presence);
                    $display("    data=%h rejected=%b, actual drive=%b busy=%b done=%b",
                             want.read_data, want.rejected, got.drive_low, got.busy,
                             got.done);
                    $display("    presence=%b data=%h rejected=%b",
                             got.presence, got.read_data, got.rejected);
                end
            end
        end
    end

    function automatic logic [9:0] phase_length(bus_phase_t p);
        case (p)
            BUS_PREAMBLE: return timing[CFG_PREAMBLE];
            RST_LOW:      return timing[CFG_RESET_LOW];
            RST_WAIT:     return timing[CFG_PRESENCE_WAIT];
            RST_TAIL:     return timing[CFG_RESET_TAIL];
            WR_LOW:       return data_shift[bit_sel] ? timing[CFG_WRITE_ONE_LOW]
                                                     : timing[CFG_WRITE_ZERO_LOW];
            WR_RECOVER:   return data_shift[bit_sel] ? WRITE_ONE_RECOVER
                                                     : WRITE_ZERO_RECOVER;
            RD_LOW:       return timing[CFG_READ_LOW];
            RD_WAIT:      return timing[CFG_READ_SAMPLE];
            RD_TAIL:      return READ_SLOT_TAIL;
            default:      return 10'd0;
        endcase
    endfunction

    // Work done when phase p runs out; returns the phase that follows.
    function automatic bus_phase_t close_phase(bus_phase_t p, logic line);
        case (p)
            BUS_PREAMBLE:
                case (active_op)
                    OP_RESET: return RST_LOW;
                    OP_WRITE: return WR_LOW;
                    OP_READ:  return RD_LOW;
                    default:  return BUS_IDLE;
                endcase
            RST_LOW:
                return RST_WAIT;
            RST_WAIT:
            begin
                presence_flag = !line;
                return RST_TAIL;
            end
            WR_LOW:
                return WR_RECOVER;
            RD_LOW:
                return RD_WAIT;
            RD_WAIT:
            begin
                data_shift = {line, data_shift[7:1]};
                return RD_TAIL;
            end
            WR_RECOVER, RD_TAIL:
            begin
                if (bit_sel == 3'd7)
                    return BUS_IDLE;
                bit_sel = bit_sel + 3'd1;
                if (p == WR_RECOVER)
                    return WR_LOW;
                return RD_LOW;
            end
            default:
                return BUS_IDLE;
        endcase
    endfunction

    // Zero-length phases fall through at once, all on the same line level.
    function automatic logic open_phase(bus_phase_t p, logic line);
        bus_phase_t nxt;
        nxt = p;
        bus_phase = nxt;
        slot_ticks = 10'd0;
        while (nxt != BUS_IDLE && phase_length(nxt) == 10'd0)
        begin
            nxt = close_phase(nxt, line);
            bus_phase = nxt;
            slot_ticks = 10'd0;
        end
        return nxt == BUS_IDLE;
    endfunction

    function automatic bus_result_t predict_result(op_t op, logic [7:0] wd, logic line);
        bus_result_t r;
        logic        low_now;
        r = '0;
        low_now = bus_phase inside {RST_LOW, WR_LOW, RD_LOW};
        r.drive_low = low_now;
        if (op != OP_TICK)
        begin
            if (bus_phase != BUS_IDLE)
                r.rejected = 1'b1;
            else
            begin
                active_op = op;
                bit_sel = 3'd0;
                data_shift = (op == OP_WRITE) ? wd : 8'h00;
                presence_flag = 1'b0;
                r.done = open_phase(BUS_PREAMBLE, line);
            end
        end
        else if (bus_phase != BUS_IDLE)
        begin
            slot_ticks = slot_ticks + 10'd1;
            if (slot_ticks >= phase_length(bus_phase))
                r.done = open_phase(close_phase(bus_phase, line), line);
        end
        r.busy = (bus_phase != BUS_IDLE);
        r.presence = r.done && active_op == OP_RESET && presence_flag;
        r.read_data = (r.done && active_op == OP_READ) ? data_shift : 8'h00;
        return r;
    endfunction

    task automatic send_request(op_t op, logic [7:0] wd, logic line);
        bus_result_t r;
        if (pacing_on)
        begin
            case ((requests_sent - ignored_requests - pacing_base) * 4 / RANDOM_ITEMS)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= op;
        cmd_ch.write_data <= wd;
        cmd_ch.line_level <= line;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
        r = predict_result(op, wd, line);
        predicted_results.push_back(r);
        requests_sent++;
        if (r.rejected || (op == OP_TICK && !r.busy && !r.done))
            ignored_requests++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted result has been returned.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
        while (predicted_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_timing(cfg_idx_t idx, logic [9:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        timing[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_timing_set(logic [9:0] pre, logic [9:0] rst_low,
                                   logic [9:0] pres_wait, logic [9:0] rst_tail,
                                   logic [9:0] one_low, logic [9:0] zero_low,
                                   logic [9:0] rd_low, logic [9:0] rd_sample);
        wait_drained();
        write_timing(CFG_PREAMBLE, pre);
        write_timing(CFG_RESET_LOW, rst_low);
        write_timing(CFG_PRESENCE_WAIT, pres_wait);
        write_timing(CFG_RESET_TAIL, rst_tail);
        write_timing(CFG_WRITE_ONE_LOW, one_low);
        write_timing(CFG_WRITE_ZERO_LOW, zero_low);
        write_timing(CFG_READ_LOW, rd_low);
        write_timing(CFG_READ_SAMPLE, rd_sample);
    endtask

    task automatic tick_until_idle(int refuse_pct, int line_mode);
        logic line;
        while (bus_phase != BUS_IDLE)
        begin
            line = (line_mode == LINE_RANDOM) ? 1'($urandom) : line_mode[0];
            if ($urandom_range(99) < refuse_pct)
                send_request(op_t'($urandom_range(3, 1)), 8'($urandom), line);
            else
                send_request(OP_TICK, 8'($urandom), line);
        end
    endtask

    task automatic randomize_timings();
        // Now and then the whole reset sequence collapses to a single request.
        if ($urandom_range(7) == 0)
            load_timing_set(10'd0, 10'd0, 10'd0, 10'd0, 10'($urandom_range(4, 1)),
                            10'($urandom_range(6, 1)), 10'($urandom_range(4, 1)),
                            10'($urandom_range(4, 1)));
        else
            load_timing_set(10'($urandom_range(4)), 10'($urandom_range(8, 1)),
                            10'($urandom_range(8, 1)), 10'($urandom_range(8)),
                            10'($urandom_range(4, 1)), 10'($urandom_range(6, 1)),
                            10'($urandom_range(4, 1)), 10'($urandom_range(4, 1)));
    endtask

    task automatic test_idle_ticks();
        send_request(OP_TICK, 8'h00, 1'b0);
        send_request(OP_TICK, 8'hFF, 1'b1);
    endtask

    task automatic test_reset_presence();
        load_timing_set(10'd2, 10'd3, 10'd2, 10'd1, 10'd1, 10'd2, 10'd1, 10'd1);
        send_request(OP_RESET, 8'h00, 1'b1);
        send_request(OP_TICK, 8'h00, 1'b1);
        send_request(OP_WRITE, 8'h3C, 1'b0);
        tick_until_idle(0, LINE_LOW);
        send_request(OP_RESET, 8'h00, 1'b0);
        tick_until_idle(30, LINE_HIGH);
    endtask

    task automatic test_timing_change_mid_phase();
        load_timing_set(10'd0, 10'd20, 10'd1, 10'd0, 10'd1, 10'd2, 10'd1, 10'd1);
        send_request(OP_RESET, 8'h00, 1'b1);
        repeat (10)
            send_request(OP_TICK, 8'h00, 1'b1);
        // The low pulse has already run past the shorter length.
        wait_drained();
        write_timing(CFG_RESET_LOW, 10'd3);
        tick_until_idle(0, LINE_LOW);
    endtask

    task automatic test_reset_without_delay();
        load_timing_set(10'd0, 10'd0, 10'd0, 10'd0, 10'd1, 10'd1, 10'd1, 10'd1);
        send_request(OP_RESET, 8'h00, 1'b0);
        send_request(OP_RESET, 8'h00, 1'b1);
    endtask

    task automatic test_write_bytes();
        load_timing_set(10'd1, 10'd1, 10'd1, 10'd1, 10'd2, 10'd3, 10'd1, 10'd1);
        send_request(OP_WRITE, 8'h00, 1'b1);
        tick_until_idle(0, LINE_HIGH);
        send_request(OP_WRITE, 8'hFF, 1'b0);
        tick_until_idle(5, LINE_RANDOM);
    endtask

    task automatic test_read_bytes();
        send_request(OP_READ, 8'hA5, 1'b0);
        tick_until_idle(0, LINE_HIGH);
        send_request(OP_READ, 8'h5A, 1'b1);
        tick_until_idle(5, LINE_RANDOM);
    endtask

    // The reset pulse runs the tick counter all the way to its top value.
    task automatic test_longest_timings();
        load_timing_set(10'd1, 10'd1023, 10'd1, 10'd1,
                        10'd1, 10'd1, 10'd1, 10'd1);
        send_request(OP_RESET, 8'h00, 1'b1);
        tick_until_idle(0, LINE_LOW);
    endtask

    task automatic test_random_traffic();
        int   choice;
        op_t  cmd_op;
        pacing_base = requests_sent - ignored_requests;
        pacing_on = 1'b1;
        randomize_timings();
        while (requests_sent - ignored_requests - pacing_base < RANDOM_ITEMS)
        begin
            if ($urandom_range(5) == 0)
                randomize_timings();
            if ($urandom_range(9) == 0)
                send_request(OP_TICK, 8'($urandom), 1'($urandom));
            choice = $urandom_range(3);
            case (choice)
                0, 1:    cmd_op = OP_RESET;
                2:       cmd_op = OP_WRITE;
                default: cmd_op = OP_READ;
            endcase
            send_request(cmd_op, 8'($urandom), 1'($urandom));
            tick_until_idle(8, LINE_RANDOM);
        end
        pacing_on = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_PREAMBLE;
        cfg_wdata         = 10'd0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = OP_TICK;
        cmd_ch.write_data = 8'h00;
        cmd_ch.line_level = 1'b1;
        res_ch.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        pacing_on         = 1'b0;

        timing[CFG_PREAMBLE]       = CFG_RESET_VALUE.preamble_ticks;
        timing[CFG_RESET_LOW]      = CFG_RESET_VALUE.reset_low_ticks;
        timing[CFG_PRESENCE_WAIT]  = CFG_RESET_VALUE.presence_wait_ticks;
        timing[CFG_RESET_TAIL]     = CFG_RESET_VALUE.reset_tail_ticks;
        timing[CFG_WRITE_ONE_LOW]  = CFG_RESET_VALUE.write_one_low_ticks;
        timing[CFG_WRITE_ZERO_LOW] = CFG_RESET_VALUE.write_zero_low_ticks;
        timing[CFG_READ_LOW]       = CFG_RESET_VALUE.read_low_ticks;
        timing[CFG_READ_SAMPLE]    = CFG_RESET_VALUE.read_sample_ticks;
        bus_phase     = BUS_IDLE;
        slot_ticks    = 10'd0;
        bit_sel       = 3'd0;
        data_shift    = 8'h00;
        active_op     = OP_TICK;
        presence_flag = 1'b0;

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_ticks();
        test_reset_presence();
        test_timing_change_mid_phase();
        test_reset_without_delay();
        test_write_bytes();
        test_read_bytes();
        test_longest_timings();
        test_random_traffic();

        wait_drained();
        repeat (4)
            @(posedge clk);

        $display("Sent %0d requests (%0d ticks or commands ignored), checked %0d results.",
                 requests_sent, ignored_requests, results_checked);
        $display("Completed %0d bus operations, %0d commands refused while busy.",
                 ops_completed, refusals_seen);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
